FILE: rtl/api_frame_deframer_defines.svh
// ---------------------------------------------------------------------------
// API frame deframer assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef API_FRAME_DEFRAMER_DEFINES_SVH
`define API_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off while in reset
`define AFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afd assertion failed");
// next-cycle implication
`define AFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afd assertion failed");
`else
`define AFD_ASSERT_IMP(lbl, ante, cons)
`define AFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/afd_pkg.sv
// ---------------------------------------------------------------------------
// API frame deframer package
// Parser phases, verdict codes and framing constants.
// ---------------------------------------------------------------------------
package afd_pkg;

  localparam logic [7:0]  START_BYTE      = 8'h7E;
  localparam logic [7:0]  SUM_BASE        = 8'hFF;
  localparam logic [15:0] HEADER_AFTER_ID = 16'd4;   // source (2) + strength + options
  localparam int          MAX_PAYLOAD     = 256;
  localparam logic [15:0] MAX_PAYLOAD_W   = 16'(MAX_PAYLOAD);
  localparam logic [7:0]  API_ID_RESET    = 8'h81;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_LEN_HI = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_API    = 4'd3,
    PH_SRC_HI = 4'd4,
    PH_SRC_LO = 4'd5,
    PH_RSSI   = 4'd6,
    PH_OPT    = 4'd7,
    PH_DATA   = 4'd8,
    PH_CHECK  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SUM   = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_WRONG_ID  = 3'd3,
    ST_SHORT     = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

endpackage

FILE: rtl/api_frame_deframer.sv
// ---------------------------------------------------------------------------
// API frame deframer
// Receive parser for radio modem API frames with streaming payload output.
// ---------------------------------------------------------------------------
// One received byte is taken per cycle, back to back, whenever the result
// register is free or is being emptied in the same cycle; the parser state
// machine and the result register together set that rate of one byte per
// clock, and a byte's result is valid in the cycle after it is accepted.
// Payload bytes come out as they arrive, tagged with the frame header; every
// frame that gets past its start byte and length ends with exactly one
// verdict, after which the parser hunts for the next 0x7E. No clearing pass
// is needed after reset. The API identifier register resets to 0x81; the user
// must write it through the cfg port while idle; the block does not check.
`include "api_frame_deframer_defines.svh"

module api_frame_deframer
  import afd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_api_id,
  // received bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_frame_status,
  output logic [15:0] out_source_address,
  output logic [7:0]  out_signal_strength,
  output logic [7:0]  out_option_bits,
  output logic [8:0]  out_payload_count
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  api_id_r;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  rssi_r, rssi_nxt;
  logic [7:0]  opt_r, opt_nxt;
  logic [8:0]  cnt_r, cnt_nxt;

  logic        out_valid_r;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [15:0] out_src_r, out_src_nxt;
  logic [7:0]  out_rssi_r, out_rssi_nxt;
  logic [7:0]  out_opt_r, out_opt_nxt;
  logic [8:0]  out_cnt_r, out_cnt_nxt;
  logic        emit;

  logic        in_fire;
  logic [15:0] len_full;
  logic [15:0] api_left;
  logic [15:0] opt_left;
  logic [15:0] data_left;
  logic [7:0]  sum_add;
  logic        len_zero;
  logic        id_bad;
  logic        too_short;
  logic        too_long;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign len_full  = {frame_len_r[15:8], in_rx_byte};
  assign api_left  = frame_len_r - 16'd1;
  assign opt_left  = bytes_left_r - HEADER_AFTER_ID;
  assign data_left = bytes_left_r - 16'd1;
  assign sum_add   = sum_r + in_rx_byte;
  assign len_zero  = (len_full == 16'd0);
  assign id_bad    = (in_rx_byte != api_id_r);
  assign too_short = (api_left < HEADER_AFTER_ID);
  assign too_long  = (opt_left > MAX_PAYLOAD_W);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LEN_HI: phase_nxt = PH_LEN_LO;
      PH_LEN_LO: phase_nxt = len_zero ? PH_HUNT : PH_API;
      PH_API:    phase_nxt = (id_bad || too_short) ? PH_HUNT : PH_SRC_HI;
      PH_SRC_HI: phase_nxt = PH_SRC_LO;
      PH_SRC_LO: phase_nxt = PH_RSSI;
      PH_RSSI:   phase_nxt = PH_OPT;
      PH_OPT: begin
        if (too_long) begin
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = (opt_left == 16'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA:   phase_nxt = (data_left == 16'd0) ? PH_CHECK : PH_DATA;
      PH_CHECK:  phase_nxt = PH_HUNT;
      default:   phase_nxt = (in_rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
    endcase
  end

  // datapath and results
  always_comb begin
    frame_len_nxt  = frame_len_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    src_nxt        = src_r;
    rssi_nxt       = rssi_r;
    opt_nxt        = opt_r;
    cnt_nxt        = cnt_r;
    emit           = 1'b0;
    out_kind_nxt   = KIND_VERDICT;
    out_byte_nxt   = 8'd0;
    out_status_nxt = ST_OK;
    out_src_nxt    = 16'd0;
    out_rssi_nxt   = 8'd0;
    out_opt_nxt    = 8'd0;
    out_cnt_nxt    = 9'd0;
    case (phase_r)
      PH_LEN_HI: frame_len_nxt = {in_rx_byte, 8'd0};
      PH_LEN_LO: begin
        frame_len_nxt = len_full;
        if (len_zero) begin
          emit           = 1'b1;
          out_status_nxt = ST_ZERO_LEN;
        end
      end
      PH_API: begin
        sum_nxt        = sum_add;
        bytes_left_nxt = api_left;
        if (id_bad) begin
          emit           = 1'b1;
          out_status_nxt = ST_WRONG_ID;
        end else if (too_short) begin
          emit           = 1'b1;
          out_status_nxt = ST_SHORT;
        end
      end
      PH_SRC_HI: begin
        sum_nxt = sum_add;
        src_nxt = {in_rx_byte, 8'd0};
      end
      PH_SRC_LO: begin
        sum_nxt = sum_add;
        src_nxt = {src_r[15:8], in_rx_byte};
      end
      PH_RSSI: begin
        sum_nxt  = sum_add;
        rssi_nxt = in_rx_byte;
      end
      PH_OPT: begin
        sum_nxt        = sum_add;
        opt_nxt        = in_rx_byte;
        bytes_left_nxt = opt_left;
        if (too_long) begin
          emit           = 1'b1;
          out_status_nxt = ST_TOO_LONG;
        end else begin
          cnt_nxt = opt_left[8:0];
        end
      end
      PH_DATA: begin
        sum_nxt        = sum_add;
        bytes_left_nxt = data_left;
        emit           = 1'b1;
        out_kind_nxt   = KIND_PAYLOAD;
        out_byte_nxt   = in_rx_byte;
        out_src_nxt    = src_r;
        out_rssi_nxt   = rssi_r;
        out_opt_nxt    = opt_r;
        out_cnt_nxt    = cnt_r;
      end
      PH_CHECK: begin
        emit           = 1'b1;
        out_status_nxt = (in_rx_byte == (SUM_BASE - sum_r)) ? ST_OK : ST_BAD_SUM;
        out_src_nxt    = src_r;
        out_rssi_nxt   = rssi_r;
        out_opt_nxt    = opt_r;
        out_cnt_nxt    = cnt_r;
      end
      default: begin
        // start byte clears the frame context
        if (in_rx_byte == START_BYTE) begin
          sum_nxt        = 8'd0;
          frame_len_nxt  = 16'd0;
          bytes_left_nxt = 16'd0;
          src_nxt        = 16'd0;
          rssi_nxt       = 8'd0;
          opt_nxt        = 8'd0;
          cnt_nxt        = 9'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      api_id_r     <= API_ID_RESET;
      frame_len_r  <= 16'd0;
      bytes_left_r <= 16'd0;
      sum_r        <= 8'd0;
      src_r        <= 16'd0;
      rssi_r       <= 8'd0;
      opt_r        <= 8'd0;
      cnt_r        <= 9'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        api_id_r <= cfg_expected_api_id;
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        frame_len_r  <= frame_len_nxt;
        bytes_left_r <= bytes_left_nxt;
        sum_r        <= sum_nxt;
        src_r        <= src_nxt;
        rssi_r       <= rssi_nxt;
        opt_r        <= opt_nxt;
        cnt_r        <= cnt_nxt;
        out_valid_r  <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load only with a new request
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r   <= out_kind_nxt;
      out_byte_r   <= out_byte_nxt;
      out_status_r <= out_status_nxt;
      out_src_r    <= out_src_nxt;
      out_rssi_r   <= out_rssi_nxt;
      out_opt_r    <= out_opt_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_payload_byte    = out_byte_r;
  assign out_frame_status    = out_status_r;
  assign out_source_address  = out_src_r;
  assign out_signal_strength = out_rssi_r;
  assign out_option_bits     = out_opt_r;
  assign out_payload_count   = out_cnt_r;

  `AFD_ASSERT_NXT(a_data_emits, in_fire && phase_r == PH_DATA, out_valid_r && out_kind_r == KIND_PAYLOAD)
  `AFD_ASSERT_NXT(a_check_ends, in_fire && phase_r == PH_CHECK, out_valid_r && out_kind_r == KIND_VERDICT && phase_r == PH_HUNT)
  `AFD_ASSERT_IMP(a_data_bounds, phase_r == PH_DATA, bytes_left_r != 16'd0 && bytes_left_r <= MAX_PAYLOAD_W)
  `AFD_ASSERT_IMP(a_payload_ok, out_valid_r && out_kind_r == KIND_PAYLOAD, out_status_r == ST_OK)

endmodule

FILE: test/api_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// API frame deframer testbench
// Streams received bytes into the parser, tracks the frame state alongside
// it, and compares every payload byte and frame verdict as it comes out.
// Runs a short set of hand-built frames, then random frame traffic under
// several API identifier settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
module api_frame_deframer_tb;
  import afd_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 45;
  localparam int IDLE_PCT    = 19;
  localparam int REPORT_MAX  = 10;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [15:0] src;
    logic [7:0]  rssi;
    logic [7:0]  opt;
    logic [8:0]  count;
  } rx_result_t;

  // Follows the parser byte by byte and holds the results it owes.
  class deframe_board;
    logic [7:0]  api_id;
    phase_t      phase;
    logic [15:0] frame_len;
    logic [15:0] bytes_left;
    logic [7:0]  sum;
    logic [15:0] src;
    logic [7:0]  rssi;
    logic [7:0]  opt;
    logic [8:0]  count;
    rx_result_t  results_due[$];
    int          mismatches;

    function new();
      api_id     = API_ID_RESET;
      phase      = PH_HUNT;
      frame_len  = '0;
      bytes_left = '0;
      sum        = '0;
      src        = '0;
      rssi       = '0;
      opt        = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function void set_api_id(logic [7:0] v);
      api_id = v;
    endfunction

    function bit hunting();
      return phase == PH_HUNT;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // zero-length, wrong-id, short and too-long verdicts go out with a blank header
    function void owe_verdict(logic [2:0] status, bit with_header);
      rx_result_t r;
      r.kind   = KIND_VERDICT;
      r.data   = 8'h00;
      r.status = status;
      r.src    = with_header ? src : 16'h0000;
      r.rssi   = with_header ? rssi : 8'h00;
      r.opt    = with_header ? opt : 8'h00;
      r.count  = with_header ? count : 9'd0;
      results_due.push_back(r);
      phase = PH_HUNT;
    endfunction

    function void take_byte(logic [7:0] b);
      rx_result_t r;
      case (phase)
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len[7:0] = b;
          if (frame_len == 16'h0000) owe_verdict(ST_ZERO_LEN, 1'b0);
          else phase = PH_API;
        end
        PH_API: begin
          sum += b;
          bytes_left = frame_len - 16'd1;
          if (b != api_id) owe_verdict(ST_WRONG_ID, 1'b0);
          else if (bytes_left < HEADER_AFTER_ID) owe_verdict(ST_SHORT, 1'b0);
          else phase = PH_SRC_HI;
        end
        PH_SRC_HI: begin
          sum += b;
          src = {b, 8'h00};
          phase = PH_SRC_LO;
        end
        PH_SRC_LO: begin
          sum += b;
          src[7:0] = b;
          phase = PH_RSSI;
        end
        PH_RSSI: begin
          sum += b;
          rssi = b;
          phase = PH_OPT;
        end
        PH_OPT: begin
          sum += b;
          opt = b;
          bytes_left = bytes_left - HEADER_AFTER_ID;
          if (bytes_left > MAX_PAYLOAD_W) begin
            owe_verdict(ST_TOO_LONG, 1'b0);
          end else begin
            count = bytes_left[8:0];
            phase = (bytes_left == 16'h0000) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          sum += b;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'h0000) phase = PH_CHECK;
          r.kind   = KIND_PAYLOAD;
          r.data   = b;
          r.status = ST_OK;
          r.src    = src;
          r.rssi   = rssi;
          r.opt    = opt;
          r.count  = count;
          results_due.push_back(r);
        end
        PH_CHECK: begin
          owe_verdict((b == SUM_BASE - sum) ? ST_OK : ST_BAD_SUM, 1'b1);
        end
        default: begin
          if (b == START_BYTE) begin
            sum        = '0;
            frame_len  = '0;
            bytes_left = '0;
            src        = '0;
            rssi       = '0;
            opt        = '0;
            count      = '0;
            phase      = PH_LEN_HI;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      bit bad;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("deframer: result with nothing owed: kind=%0d byte=%02h st=%0d",
                   got.kind, got.data, got.status);
        return;
      end
      want = results_due.pop_front();
      bad = (got.kind !== want.kind) || (got.data !== want.data) ||
            (got.status !== want.status) || (got.src !== want.src) ||
            (got.rssi !== want.rssi) || (got.opt !== want.opt) ||
            (got.count !== want.count);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("deframer: exp kind=%0d byte=%02h st=%0d src=%04h rssi=%02h opt=%02h n=%0d",
                   want.kind, want.data, want.status, want.src, want.rssi, want.opt,
                   want.count);
          $display("deframer: got kind=%0d byte=%02h st=%0d src=%04h rssi=%02h opt=%02h n=%0d",
                   got.kind, got.data, got.status, got.src, got.rssi, got.opt, got.count);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_expected_api_id = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_frame_status;
  logic [15:0] out_source_address;
  logic [7:0]  out_signal_strength;
  logic [7:0]  out_option_bits;
  logic [8:0]  out_payload_count;

  deframe_board board;
  logic [7:0]   tx_q[$];
  logic [7:0]   payload_q[$];
  bit           calm = 1'b0;
  int           cycle_count = 0;

  api_frame_deframer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expected_api_id (cfg_expected_api_id),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_frame_status    (out_frame_status),
    .out_source_address  (out_source_address),
    .out_signal_strength (out_signal_strength),
    .out_option_bits     (out_option_bits),
    .out_payload_count   (out_payload_count)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    rx_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = out_result_kind;
      got.data   = out_payload_byte;
      got.status = out_frame_status;
      got.src    = out_source_address;
      got.rssi   = out_signal_strength;
      got.opt    = out_option_bits;
      got.count  = out_payload_count;
      board.check_result(got);
    end
  end

  // Starts and ends on a falling edge; valid stays up between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_byte(b);
    @(negedge clk);
  endtask

  task automatic flush_tx();
    foreach (tx_q[i]) send_byte(tx_q[i]);
    tx_q.delete();
  endtask

  // Pad out any open frame, then hold until every owed result is out.
  task automatic settle();
    while (!board.hunting()) send_byte(8'h00);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_api_id(input logic [7:0] v);
    cfg_valid           <= 1'b1;
    cfg_expected_api_id <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_api_id(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void fill_payload(int unsigned n);
    repeat (n) payload_q.push_back(8'($urandom_range(255)));
  endfunction

  // Append one frame built around payload_q; the checksum covers id through payload.
  function automatic void push_frame(input logic [15:0] len, input logic [7:0] id,
                                     input logic [15:0] src, input logic [7:0] rssi,
                                     input logic [7:0] opt, input bit bad_sum);
    logic [7:0] chk;
    chk = id + src[15:8] + src[7:0] + rssi + opt;
    tx_q.push_back(START_BYTE);
    tx_q.push_back(len[15:8]);
    tx_q.push_back(len[7:0]);
    tx_q.push_back(id);
    tx_q.push_back(src[15:8]);
    tx_q.push_back(src[7:0]);
    tx_q.push_back(rssi);
    tx_q.push_back(opt);
    foreach (payload_q[i]) begin
      tx_q.push_back(payload_q[i]);
      chk += payload_q[i];
    end
    chk = SUM_BASE - chk;
    if (bad_sum) chk ^= 8'($urandom_range(1, 255));
    tx_q.push_back(chk);
    payload_q.delete();
  endfunction

  function automatic void push_random_frame(input int unsigned n, input logic [7:0] id,
                                            input bit bad_sum);
    fill_payload(n);
    push_frame(16'(n + 5), id, 16'($urandom), 8'($urandom), 8'($urandom), bad_sum);
  endfunction

  task automatic random_phase(input logic [7:0] id, input bit with_full_frame);
    int unsigned sent;
    int unsigned roll;
    int unsigned n;
    int unsigned k;
    bit          noise;
    sent = 0;
    if (with_full_frame) begin
      push_random_frame(MAX_PAYLOAD, id, 1'b0);
      sent += tx_q.size();
      flush_tx();
    end
    while (sent < PHASE_BYTES) begin
      roll  = $urandom_range(99);
      n     = ($urandom_range(99) == 0) ? $urandom_range(200, MAX_PAYLOAD)
                                        : $urandom_range(0, 16);
      noise = 1'b0;
      if (roll < 8) begin
        noise = 1'b1;
        repeat ($urandom_range(1, 4)) tx_q.push_back(8'($urandom_range(255)));
      end else if (roll < 12) begin
        tx_q = '{START_BYTE, 8'h00, 8'h00};
      end else if (roll < 18) begin
        push_random_frame(n, id ^ 8'($urandom_range(1, 255)), 1'b0);
      end else if (roll < 23) begin
        tx_q = '{START_BYTE, 8'h00, 8'($urandom_range(1, 4)), id};
      end else if (roll < 28) begin
        push_frame(16'($urandom_range(MAX_PAYLOAD + 6, 16'hFFFF)), id, 16'($urandom),
                   8'($urandom), 8'($urandom), 1'b0);
      end else if (roll < 33) begin
        // cut the frame short; the next frame's bytes are parsed as the rest of it
        push_random_frame(n, id, 1'b0);
        k = $urandom_range(1, tx_q.size() - 1);
        repeat (k) void'(tx_q.pop_back());
      end else begin
        push_random_frame(n, id, roll < 45);
      end
      if (!noise) sent += tx_q.size();
      flush_tx();
    end
    settle();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [7:0] id_plan [NUM_PHASES];
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_q = '{START_BYTE, 8'h00, 8'h00};
    flush_tx();
    // wrong identifier wins over a too-short length
    tx_q = '{START_BYTE, 8'h00, 8'h02, 8'h7F};
    flush_tx();
    tx_q = '{START_BYTE, 8'h00, 8'h04, API_ID_RESET};
    flush_tx();
    // one payload byte over capacity
    tx_q = '{START_BYTE, 8'h01, 8'h06, API_ID_RESET, 8'h12, 8'h34, 8'h56, 8'h78};
    flush_tx();
    push_frame(16'd5, API_ID_RESET, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
    flush_tx();
    payload_q = '{START_BYTE, 8'h00, 8'hFF};
    push_frame(16'd8, API_ID_RESET, 16'h0000, 8'h00, 8'h00, 1'b1);
    flush_tx();
    settle();

    id_plan = '{8'h00, 8'hFF, START_BYTE, 8'($urandom), 8'($urandom), API_ID_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_api_id(id_plan[p]);
      calm = (p == 3);
      random_phase(id_plan[p], p == 0);
    end
    calm = 1'b0;

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
